// ===== rtl/core/n2a_pkg.sv =====
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared types and constants for the number-to-ASCII formatter.
// ----------------------------------------------------------------------------
package n2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int SEP_W      = 8;
    localparam int CHAR_W     = 8;
    localparam int ACTION_W   = 3;
    localparam int DEC_DIGITS = 10;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int DIG_CNT_W  = $clog2(DEC_DIGITS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_ONE    = 8'd49;
    localparam logic [CHAR_W-1:0] ASCII_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] HEX_LETTER   = 8'd55;

    typedef enum logic [ACTION_W-1:0] {
        ACT_UDEC32 = 3'd0,
        ACT_SDEC8  = 3'd1,
        ACT_SDEC32 = 3'd2,
        ACT_BIN8   = 3'd3,
        ACT_HEX8   = 3'd4,
        ACT_HEX16  = 3'd5,
        ACT_HEX32  = 3'd6
    } action_t;

    // Status of the binary-to-BCD unit
    typedef struct packed {
        logic busy;
        logic done;
    } dab_status_t;

    // One digit (decimal or hex) as an uppercase ASCII character
    function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] ch;
        if (nib <= 4'd9) begin
            ch = ASCII_ZERO + {4'b0, nib};
        end else begin
            ch = HEX_LETTER + {4'b0, nib};
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/n2a_dabble.sv =====
// ----------------------------------------------------------------------------
// n2a_dabble
// Iterative binary-to-BCD converter: one add-3 and shift step per cycle.
// ----------------------------------------------------------------------------
module n2a_dabble (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [n2a_pkg::VALUE_W-1:0]    mag,
    output logic [n2a_pkg::BCD_W-1:0]      bcd,
    output n2a_pkg::dab_status_t           status
);
    import n2a_pkg::*;

    localparam int STEP_CNT_W = $clog2(VALUE_W + 1);

    logic [VALUE_W-1:0]    bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_adj;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < DEC_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                bcd_reg[4*d +: 4] + 4'd3 : bcd_reg[4*d +: 4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                bin_reg  <= mag;
                bcd_reg  <= '0;
                cnt_reg  <= STEP_CNT_W'(VALUE_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                {bcd_reg, bin_reg} <= {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
                cnt_reg            <= cnt_reg - STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign bcd         = bcd_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("dabble busy with zero step count");

    a_done_once: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("dabble done while still busy");

    a_done_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("dabble done without a conversion");

endmodule

// ===== rtl/core/number_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Formats one number as ASCII decimal, binary or hex text, one character per
// output transfer, with tlast on the final character.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_tready is low until its last character has
// been loaded into the output register. Binary and hex items go straight to
// emitting their characters. Decimal items run a 32-step binary-to-BCD
// conversion (one step per cycle in the shared shift/add-3 unit), then skip
// leading zeros at one digit per cycle, then emit one digit per cycle while
// the output accepts; output stalls hold the emitting. A '-' for a negative
// signed value goes out ahead of any digit, during the conversion unless the
// output stalls. Action code 7 is accepted and produces nothing.
module number_to_ascii_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [31:0] value, [39:32] separator
    input  logic [2:0]  s_tuser,    // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] character
    output logic        m_tlast
);
    import n2a_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_EMIT = 5'b01000,
        S_SEP  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic                  sign_reg, sign_next;
    logic [BCD_W-1:0]      shreg_reg, shreg_next;
    logic [DIG_CNT_W-1:0]  dig_cnt_reg, dig_cnt_next;
    logic                  bin_mode_reg, bin_mode_next;
    logic [SEP_W-1:0]      sep_reg, sep_next;
    logic                  has_sep_reg, has_sep_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic [VALUE_W-1:0]    in_value;
    logic [SEP_W-1:0]      in_sep;
    logic                  s_fire;
    logic                  can_load;
    logic                  dab_start;
    logic [VALUE_W-1:0]    dab_mag;
    logic [BCD_W-1:0]      dab_bcd;
    dab_status_t           dab_stat;
    logic [CHAR_W-1:0]     digit_char;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_sep   = s_tdata[VALUE_W +: SEP_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign can_load = !m_tvalid_reg || m_tready;

    assign digit_char = bin_mode_reg ?
                        (shreg_reg[BCD_W-1] ? ASCII_ONE : ASCII_ZERO) :
                        nibble_char(shreg_reg[BCD_W-1 -: 4]);

    n2a_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dab_start),
        .mag     (dab_mag),
        .bcd     (dab_bcd),
        .status  (dab_stat)
    );

    always_comb begin
        state_next    = state_reg;
        sign_next     = sign_reg;
        shreg_next    = shreg_reg;
        dig_cnt_next  = dig_cnt_reg;
        bin_mode_next = bin_mode_reg;
        sep_next      = sep_reg;
        has_sep_next  = has_sep_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        dab_start     = 1'b0;
        dab_mag       = in_value;

        if (s_fire) begin
            sep_next      = in_sep;
            bin_mode_next = 1'b0;
            has_sep_next  = (in_sep != '0);
            unique case (action_t'(s_tuser))
                ACT_UDEC32: begin
                    dab_start  = 1'b1;
                    sign_next  = 1'b0;
                    state_next = S_CONV;
                end
                ACT_SDEC8: begin
                    dab_start  = 1'b1;
                    sign_next  = in_value[7];
                    dab_mag    = {24'b0, in_value[7] ?
                                  8'(8'd0 - in_value[7:0]) : in_value[7:0]};
                    state_next = S_CONV;
                end
                ACT_SDEC32: begin
                    dab_start  = 1'b1;
                    sign_next  = in_value[VALUE_W-1];
                    dab_mag    = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
                    state_next = S_CONV;
                end
                ACT_BIN8: begin
                    shreg_next    = {in_value[7:0], 32'b0};
                    dig_cnt_next  = DIG_CNT_W'(8);
                    bin_mode_next = 1'b1;
                    sign_next     = 1'b0;
                    state_next    = S_EMIT;
                end
                ACT_HEX8: begin
                    shreg_next   = {in_value[7:0], 32'b0};
                    dig_cnt_next = DIG_CNT_W'(2);
                    sign_next    = 1'b0;
                    state_next   = S_EMIT;
                end
                ACT_HEX16: begin
                    shreg_next   = {in_value[15:0], 24'b0};
                    dig_cnt_next = DIG_CNT_W'(4);
                    sign_next    = 1'b0;
                    state_next   = S_EMIT;
                end
                ACT_HEX32: begin
                    shreg_next   = {in_value, 8'b0};
                    dig_cnt_next = DIG_CNT_W'(8);
                    sign_next    = 1'b0;
                    state_next   = S_EMIT;
                end
                default: begin
                    // undefined action: drop the item
                    sign_next  = 1'b0;
                    state_next = S_IDLE;
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
            end
            S_CONV: begin
                if (dab_stat.done) begin
                    shreg_next   = dab_bcd;
                    dig_cnt_next = DIG_CNT_W'(DEC_DIGITS);
                    has_sep_next = 1'b0;
                    state_next   = S_SKIP;
                end
            end
            S_SKIP: begin
                if (dig_cnt_reg > DIG_CNT_W'(1) && shreg_reg[BCD_W-1 -: 4] == 4'd0) begin
                    shreg_next   = shreg_reg << 4;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_load && !sign_reg) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = digit_char;
                    m_tlast_next  = (dig_cnt_reg == DIG_CNT_W'(1)) && !has_sep_reg;
                    shreg_next    = bin_mode_reg ? (shreg_reg << 1) : (shreg_reg << 4);
                    dig_cnt_next  = dig_cnt_reg - DIG_CNT_W'(1);
                    if (dig_cnt_reg == DIG_CNT_W'(1)) begin
                        state_next = has_sep_reg ? S_SEP : S_IDLE;
                    end
                end
            end
            S_SEP: begin
                if (can_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = sep_reg;
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Minus sign goes out ahead of any digit
        if (sign_reg && can_load && state_reg != S_IDLE) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = ASCII_MINUS;
            m_tlast_next  = 1'b0;
            sign_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sign_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            dig_cnt_reg  <= '0;
            has_sep_reg  <= 1'b0;
            bin_mode_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sign_reg     <= sign_next;
            m_tvalid_reg <= m_tvalid_next;
            dig_cnt_reg  <= dig_cnt_next;
            has_sep_reg  <= has_sep_next;
            bin_mode_reg <= bin_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        shreg_reg   <= shreg_next;
        sep_reg     <= sep_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_sign_gone: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !sign_reg)
        else $error("minus sign still pending at idle");

    a_emit_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> dig_cnt_reg != '0)
        else $error("emitting with no digits left");

    a_done_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        dab_stat.done |-> state_reg == S_CONV)
        else $error("conversion finished outside the conversion state");

    a_sep_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SEP |-> sep_reg != '0)
        else $error("separator state with zero separator");

endmodule
